@@ hdl/rcpt_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpt_pkg: shared types and constants for the RC pulse tank drive mixer
// Register map, reset values and the records passed between the modules.
// ----------------------------------------------------------------------------
package rcpt_pkg;

    localparam int unsigned WidthW   = 8;
    localparam int unsigned GainW    = 12;
    localparam int unsigned OffsetW  = 11;
    localparam int unsigned DutyW    = 8;
    localparam int unsigned AddrW    = 4;
    localparam int unsigned DataW    = 32;

    localparam logic [WidthW-1:0]  RST_MIN_WIDTH    = 8'd120;
    localparam logic [WidthW-1:0]  RST_MAX_WIDTH    = 8'd255;
    localparam logic [GainW-1:0]   RST_GAIN_Q8      = 12'd1242;
    localparam logic [OffsetW-1:0] RST_DRIVE_OFFSET = 11'd967;
    localparam logic [WidthW-1:0]  NEUTRAL_WIDTH    = 8'd200;
    localparam logic [WidthW-1:0]  COUNT_MAX        = 8'd255;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_MIN_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH    = 2'd1;
    localparam logic [1:0] REG_GAIN_Q8      = 2'd2;
    localparam logic [1:0] REG_DRIVE_OFFSET = 2'd3;

    typedef struct packed {
        logic [WidthW-1:0]  min_width;
        logic [WidthW-1:0]  max_width;
        logic [GainW-1:0]   gain_q8;
        logic [OffsetW-1:0] drive_offset;
    } cfg_t;

    typedef struct packed {
        logic [DutyW-1:0] right_forward;
        logic [DutyW-1:0] right_reverse;
        logic [DutyW-1:0] left_forward;
        logic [DutyW-1:0] left_reverse;
        logic             fault_stop;
    } duty_t;

endpackage

@@ hdl/rcpt_channel.sv @@
// ----------------------------------------------------------------------------
// rcpt_channel: pulse width capture for one receiver input
// Counts ticks since the rising edge and latches an in-range width on the
// falling edge.
// ----------------------------------------------------------------------------
module rcpt_channel
    import rcpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick,
    input  logic              level,
    input  cfg_t              cfg,
    output logic [WidthW-1:0] width
);

    logic              prev_reg;
    logic [WidthW-1:0] count_reg;
    logic [WidthW-1:0] count_next;
    logic [WidthW-1:0] width_reg;
    logic [WidthW-1:0] width_next;
    logic              rising;
    logic              falling;

    assign rising  = level & ~prev_reg;
    assign falling = ~level & prev_reg;

    always_comb
    begin
        if (rising)
        begin
            count_next = '0;
        end
        else if (count_reg != COUNT_MAX)
        begin
            count_next = count_reg + WidthW'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        width_next = width_reg;
        if (falling && (count_next > cfg.min_width) && (count_next < cfg.max_width))
        begin
            width_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            count_reg <= '0;
            width_reg <= NEUTRAL_WIDTH;
        end
        else if (tick)
        begin
            prev_reg  <= level;
            count_reg <= count_next;
            width_reg <= width_next;
        end
    end

    assign width = width_reg;

endmodule

@@ hdl/rcpt_mix.sv @@
// ----------------------------------------------------------------------------
// rcpt_mix: width to drive scaling, tank mixing and duty split
// Scales both widths, forms right = b + a and left = b - a, and splits each
// side into saturated forward and reverse duties, all zero on a fault.
// ----------------------------------------------------------------------------
module rcpt_mix
    import rcpt_pkg::*;
(
    input  logic [WidthW-1:0] width_a,
    input  logic [WidthW-1:0] width_b,
    input  logic              fault,
    input  cfg_t              cfg,
    output duty_t             duty
);

    localparam int unsigned ProdW  = WidthW + GainW;
    localparam int unsigned SumW   = 14;

    logic [ProdW-1:0]       prod_a;
    logic [ProdW-1:0]       prod_b;
    logic signed [SumW-1:0] drive_a;
    logic signed [SumW-1:0] drive_b;
    logic signed [SumW-1:0] right_sum;
    logic signed [SumW-1:0] left_sum;
    logic [DutyW-1:0]       right_mag;
    logic [DutyW-1:0]       left_mag;

    function automatic logic [DutyW-1:0] sat_mag(input logic signed [SumW-1:0] v);
        logic [SumW-1:0] mag;
        mag = v[SumW-1] ? SumW'(-v) : SumW'(v);
        if (mag > SumW'(255))
        begin
            return '1;
        end
        return mag[DutyW-1:0];
    endfunction

    assign prod_a = ProdW'(width_a) * ProdW'(cfg.gain_q8);
    assign prod_b = ProdW'(width_b) * ProdW'(cfg.gain_q8);

    // drop the 8 fraction bits, then remove the neutral offset
    assign drive_a = $signed(SumW'(prod_a[ProdW-1:8])) - $signed(SumW'(cfg.drive_offset));
    assign drive_b = $signed(SumW'(prod_b[ProdW-1:8])) - $signed(SumW'(cfg.drive_offset));

    assign right_sum = drive_b + drive_a;
    assign left_sum  = drive_b - drive_a;

    assign right_mag = sat_mag(right_sum);
    assign left_mag  = sat_mag(left_sum);

    always_comb
    begin
        duty.fault_stop    = fault;
        duty.right_forward = '0;
        duty.right_reverse = '0;
        duty.left_forward  = '0;
        duty.left_reverse  = '0;
        if (!fault)
        begin
            if (right_sum[SumW-1])
            begin
                duty.right_reverse = right_mag;
            end
            else
            begin
                duty.right_forward = right_mag;
            end
            if (left_sum[SumW-1])
            begin
                duty.left_reverse = left_mag;
            end
            else
            begin
                duty.left_forward = left_mag;
            end
        end
    end

endmodule

@@ hdl/rc_pulse_tank_drive_mixer.sv @@
// ----------------------------------------------------------------------------
// rc_pulse_tank_drive_mixer: two-channel RC pulse to tank drive mixer
// Each input transfer is one timer tick carrying both receiver levels and the
// two active-low driver fault lines. The block accepts one transfer per clock
// cycle unless the output is stalled, and returns exactly one result
// transfer per input. The channel registers update the edge counters and
// latched widths; both 8x12 width multiplies, the tank mix and the duty
// saturation then feed the output register. Registers are on an APB port at
// byte addresses 0x0 min_width, 0x4 max_width, 0x8 gain_q8 and 0xC
// drive_offset; write them only while no transfer is in flight.
// ----------------------------------------------------------------------------
module rc_pulse_tank_drive_mixer
    import rcpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              channel_a_level,
    input  logic              channel_b_level,
    input  logic              fault_n,
    input  logic              overtemp_n,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [DutyW-1:0]  right_forward,
    output logic [DutyW-1:0]  right_reverse,
    output logic [DutyW-1:0]  left_forward,
    output logic [DutyW-1:0]  left_reverse,
    output logic              fault_stop
);

    cfg_t              cfg_reg;
    logic [1:0]        reg_idx;
    logic              cfg_write;

    logic              s1_valid_reg;
    logic              s1_fault_reg;
    logic              out_valid_reg;
    duty_t             duty_reg;
    duty_t             duty_next;
    logic              out_adv;
    logic              s1_adv;
    logic              accept;
    logic [WidthW-1:0] width_a;
    logic [WidthW-1:0] width_b;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_width    <= RST_MIN_WIDTH;
            cfg_reg.max_width    <= RST_MAX_WIDTH;
            cfg_reg.gain_q8      <= RST_GAIN_Q8;
            cfg_reg.drive_offset <= RST_DRIVE_OFFSET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_MIN_WIDTH:    cfg_reg.min_width    <= pwdata[WidthW-1:0];
                REG_MAX_WIDTH:    cfg_reg.max_width    <= pwdata[WidthW-1:0];
                REG_GAIN_Q8:      cfg_reg.gain_q8      <= pwdata[GainW-1:0];
                REG_DRIVE_OFFSET: cfg_reg.drive_offset <= pwdata[OffsetW-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_WIDTH:    prdata = DataW'(cfg_reg.min_width);
            REG_MAX_WIDTH:    prdata = DataW'(cfg_reg.max_width);
            REG_GAIN_Q8:      prdata = DataW'(cfg_reg.gain_q8);
            REG_DRIVE_OFFSET: prdata = DataW'(cfg_reg.drive_offset);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign out_adv  = ~out_valid_reg | out_ready;
    assign s1_adv   = ~s1_valid_reg | out_adv;
    assign in_ready = s1_adv;
    assign accept   = in_valid & in_ready;

    // channel trackers form the first stage: their width registers hold
    // the state after the accepted tick
    rcpt_channel u_chan_a
    (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (accept),
        .level (channel_a_level),
        .cfg   (cfg_reg),
        .width (width_a)
    );

    rcpt_channel u_chan_b
    (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (accept),
        .level (channel_b_level),
        .cfg   (cfg_reg),
        .width (width_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fault_reg <= ~(fault_n & overtemp_n);
        end
    end

    rcpt_mix u_mix
    (
        .width_a (width_a),
        .width_b (width_b),
        .fault   (s1_fault_reg),
        .cfg     (cfg_reg),
        .duty    (duty_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            duty_reg <= duty_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign right_forward = duty_reg.right_forward;
    assign right_reverse = duty_reg.right_reverse;
    assign left_forward  = duty_reg.left_forward;
    assign left_reverse  = duty_reg.left_reverse;
    assign fault_stop    = duty_reg.fault_stop;

endmodule

@@ hdl/rcpt_checker.sv @@
// ----------------------------------------------------------------------------
// rcpt_checker: port-level checks for the RC pulse tank drive mixer
// Watches the result channel and its relation to input transfers.
// ----------------------------------------------------------------------------
module rcpt_checker
    import rcpt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [DutyW-1:0] right_forward,
    input logic [DutyW-1:0] right_reverse,
    input logic [DutyW-1:0] left_forward,
    input logic [DutyW-1:0] left_reverse,
    input logic             fault_stop
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(right_forward)
            && $stable(right_reverse) && $stable(left_forward)
            && $stable(left_reverse) && $stable(fault_stop))
        else $error("result changed while stalled");

    // a fault stop drives every duty to zero
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_stop |-> right_forward == '0 && right_reverse == '0
            && left_forward == '0 && left_reverse == '0)
        else $error("nonzero duty during fault stop");

    // never drive both directions on one side
    a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(right_forward != '0 && right_reverse != '0)
            && !(left_forward != '0 && left_reverse != '0))
        else $error("forward and reverse duty both nonzero");

    // a fresh result traces back to an accepted input transfer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input transfer");

endmodule

bind rc_pulse_tank_drive_mixer rcpt_checker u_rcpt_checker (.*);
